// ===== rtl/modexp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Sequencer states and configuration register indexes shared by the block.
// ----------------------------------------------------------------------------
package modexp_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_MUL,
		ST_SQR,
		ST_DONE
	} state_t;

	localparam logic [0:0] REG_MODULUS  = 1'b0;
	localparam logic [0:0] REG_EXPONENT = 1'b1;

	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} mm_ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/modexp_mulmod.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Modular multiplier
// Interleaved shift-and-add multiply, one multiplier bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module modexp_mulmod #(
	parameter int W = 16
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic [W-1:0]             a,
	input  wire logic [W-1:0]             b,
	input  wire logic [W-1:0]             m,
	output modexp_pkg::mm_ctrl_t          ctrl,
	output logic      [W-1:0]             p
);
	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  acc_q, a_q, b_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q, done_q;
	logic [W-1:0]  dbl, sum;

	// add_mod(x, y): compare x against m - y so nothing overflows.
	function automatic logic [W-1:0] add_mod(input logic [W-1:0] x, input logic [W-1:0] y,
		input logic [W-1:0] mm);
		logic [W-1:0] room;
		room = mm - y;
		return (x >= room) ? (x - room) : (x + y);
	endfunction

	always_comb begin
		dbl = add_mod(acc_q, acc_q, m);
		sum = b_q[W-1] ? add_mod(dbl, a_q, m) : dbl;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			a_q   <= a;
			b_q   <= b;
		end else if (busy_q) begin
			acc_q <= sum;
			b_q   <= {b_q[W-2:0], 1'b0};
		end
	end

	assign ctrl.start = start;
	assign ctrl.busy  = busy_q;
	assign ctrl.done  = done_q;
	assign p = acc_q;
endmodule
`default_nettype wire

// ===== rtl/modexp_reduce.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Restoring reducer
// Computes x mod m one quotient bit per cycle.
// ----------------------------------------------------------------------------
module modexp_reduce #(
	parameter int W = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [W-1:0] x,
	input  wire logic [W-1:0] m,
	output logic              done,
	output logic [W-1:0]      r
);
	localparam int CW = $clog2(W + 1);

	logic [W:0]    rem_q;
	logic [W-1:0]  x_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q, done_q;
	logic [W:0]    sh;

	assign sh = {rem_q[W-1:0], x_q[W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			x_q   <= x;
		end else if (busy_q) begin
			rem_q <= (sh >= {1'b0, m}) ? (sh - {1'b0, m}) : sh;
			x_q   <= {x_q[W-2:0], 1'b0};
		end
	end

	assign done = done_q;
	assign r = rem_q[W-1:0];
endmodule
`default_nettype wire

// ===== rtl/modular_exponentiation.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Modular exponentiation
// Right-to-left square-and-multiply over a bit-serial modular multiplier.
// ----------------------------------------------------------------------------
// Usage: write modulus (index 0) and exponent (index 1) on the cfg channel
// while the block is idle; cfg_ready is always high. Pulse start with
// base_value while busy is low. The base is first reduced modulo the
// modulus. Then for every exponent bit, LSB first, a multiply (only if the
// bit is set) and a squaring run in the shared shift-and-add multiplier.
// A start while busy is high is ignored, so one item finishes before the
// next is taken. A modulus below two gives 0 after the reduction.
// done pulses for one cycle with power_result; the receiver cannot stall.
// Reset sets modulus to 2 and exponent to 1 and returns the block to idle.
// ----------------------------------------------------------------------------
module modular_exponentiation #(
	parameter int OPERAND_BITS = 16
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	output logic                         busy,
	input  wire logic [15:0]             base_value,
	output logic                         done,
	output logic [15:0]                  power_result,
	input  wire logic                    cfg_valid,
	output logic                         cfg_ready,
	input  wire logic                    cfg_index,
	input  wire logic [15:0]             cfg_data
);
	localparam int W  = OPERAND_BITS;
	localparam int BW = $clog2(W);

	modexp_pkg::state_t  state_q, state_d;
	modexp_pkg::mm_ctrl_t mm_ctrl;
	logic [W-1:0]  mod_q, exp_q, acc_q, sq_q, e_q;
	logic [BW-1:0] bit_q;
	logic          red_start, red_done, mm_start, small_mod, last_bit;
	logic [W-1:0]  red_r, mm_p, mm_a, mm_b;
	logic [15:0]   res_q;
	logic          done_q, go_q;

	assign cfg_ready = 1'b1;
	assign small_mod = (mod_q < W'(2));
	assign last_bit  = (bit_q == BW'(W - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q <= W'(2);
			exp_q <= W'(1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				modexp_pkg::REG_MODULUS:  mod_q <= W'(cfg_data);
				modexp_pkg::REG_EXPONENT: exp_q <= W'(cfg_data);
				default: ;
			endcase
		end
	end

	modexp_reduce #(.W(W)) u_red (
		.clk(clk), .arst_n(arst_n), .start(red_start), .x(W'(base_value)),
		.m(mod_q), .done(red_done), .r(red_r)
	);

	assign mm_a = (state_q == modexp_pkg::ST_MUL) ? acc_q : sq_q;
	assign mm_b = sq_q;

	modexp_mulmod #(.W(W)) u_mm (
		.clk(clk), .arst_n(arst_n), .start(mm_start), .a(mm_a), .b(mm_b),
		.m(mod_q), .ctrl(mm_ctrl), .p(mm_p)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			modexp_pkg::ST_IDLE:   if (start) state_d = modexp_pkg::ST_REDUCE;
			modexp_pkg::ST_REDUCE: begin
				if (red_done) begin
					if (small_mod) state_d = modexp_pkg::ST_DONE;
					else if (exp_q[0]) state_d = modexp_pkg::ST_MUL;
					else state_d = modexp_pkg::ST_SQR;
				end
			end
			modexp_pkg::ST_MUL:    if (mm_ctrl.done) state_d = modexp_pkg::ST_SQR;
			modexp_pkg::ST_SQR: begin
				if (mm_ctrl.done) begin
					if (last_bit) state_d = modexp_pkg::ST_DONE;
					else if (e_q[1]) state_d = modexp_pkg::ST_MUL;
					else state_d = modexp_pkg::ST_SQR;
				end
			end
			modexp_pkg::ST_DONE:   state_d = modexp_pkg::ST_IDLE;
			default:               state_d = modexp_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		red_start = (state_q == modexp_pkg::ST_IDLE) && start;
		mm_start  = go_q;
		busy      = (state_q != modexp_pkg::ST_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= modexp_pkg::ST_IDLE;
			done_q  <= 1'b0;
			go_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == modexp_pkg::ST_DONE);
			// A multiplier pass starts as each step is entered.
			go_q <= (state_d == modexp_pkg::ST_MUL || state_d == modexp_pkg::ST_SQR)
				&& (state_d != state_q || mm_ctrl.done);
		end
	end

	always_ff @(posedge clk) begin
		if (red_start) begin
			acc_q <= W'(1);
			e_q   <= exp_q;
			bit_q <= '0;
		end
		if (state_q == modexp_pkg::ST_REDUCE && red_done) sq_q <= red_r;
		if (state_q == modexp_pkg::ST_MUL && mm_ctrl.done) acc_q <= mm_p;
		if (state_q == modexp_pkg::ST_SQR && mm_ctrl.done) begin
			sq_q  <= mm_p;
			e_q   <= e_q >> 1;
			bit_q <= bit_q + 1'b1;
		end
		if (state_q == modexp_pkg::ST_DONE)
			res_q <= small_mod ? 16'd0 : 16'(acc_q);
	end

	assign done = done_q;
	assign power_result = res_q;

`ifndef SYNTHESIS
	a_done_after_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == modexp_pkg::ST_DONE) |=> done)
		else $error("done did not follow the finish step");
	a_mm_not_restarted: assert property (@(posedge clk) disable iff (!arst_n)
		mm_ctrl.busy |-> !mm_start)
		else $error("multiplier restarted while busy");
	a_idle_no_pass: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == modexp_pkg::ST_IDLE) |-> !mm_ctrl.busy)
		else $error("multiplier busy while idle");
`endif
endmodule
`default_nettype wire
